// ===== hdl/tmx_pkg.sv =====
// ----------------------------------------------------------------------------
// tmx_pkg
// Shared types and constants of the three-axis PID elevon mixer.
// ----------------------------------------------------------------------------
package tmx_pkg;

  localparam int unsigned NUM_AXES = 3;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned ANGLE_W  = 16;
  localparam int unsigned ERR_W    = ANGLE_W + 1;
  localparam int unsigned DIFF_W   = ERR_W + 1;
  localparam int unsigned SUM_W    = 32;
  localparam int unsigned NUM_W    = 50;
  localparam int unsigned MIX_W    = NUM_W + 1;
  localparam int unsigned DRIVE_W  = 16;

  localparam int unsigned AXIS_ROLL  = 0;
  localparam int unsigned AXIS_PITCH = 1;
  localparam int unsigned AXIS_YAW   = 2;

  // Output divisor 4096 * 100 * 100 = 2^16 * 625.
  localparam int unsigned DIV_SHIFT = 16;
  localparam int unsigned DIV_ODD   = 625;
  localparam int unsigned SHR_W     = MIX_W - DIV_SHIFT;
  localparam int unsigned MAG_W     = 25;
  localparam int unsigned RECIP_SH  = 35;
  localparam logic [25:0] RECIP     = 26'((64'd1 << RECIP_SH) / DIV_ODD);
  localparam logic [SHR_W-1:0] SAT_LIM = SHR_W'(32768 * DIV_ODD);

  localparam logic [47:0] GAINS_RST        = 48'h1000_0029_0800;
  localparam logic [15:0] ROLL_TARGET_RST  = 16'sd0;
  localparam logic [15:0] PITCH_TARGET_RST = -16'sd500;
  localparam logic [15:0] YAW_TARGET_RST   = 16'sd0;

  typedef struct packed {
    logic [NUM_AXES-1:0][47:0]      gains;
    logic [NUM_AXES-1:0][ANGLE_W-1:0] target;
  } tmx_cfg_t;

  typedef struct packed {
    logic ld_err;
    logic ld_prod;
    logic ld_num;
    logic ld_mix;
    logic ld_recip;
    logic ld_out;
  } tmx_adv_t;

endpackage

// ===== hdl/tmx_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tmx_cfg_regs
// APB register file holding the axis gains and attitude targets.
// ----------------------------------------------------------------------------
module tmx_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [5:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output tmx_pkg::tmx_cfg_t cfg_o
);
  import tmx_pkg::*;

  typedef enum logic [2:0] {
    REG_ROLL_GAINS   = 3'd0,
    REG_PITCH_GAINS  = 3'd1,
    REG_YAW_GAINS    = 3'd2,
    REG_ROLL_TARGET  = 3'd3,
    REG_PITCH_TARGET = 3'd4,
    REG_YAW_TARGET   = 3'd5
  } tmx_reg_e;

  tmx_cfg_t   cfg_q;
  tmx_reg_e   reg_idx;
  logic       wr_en;

  assign reg_idx = tmx_reg_e'(paddr[5:3]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gains[AXIS_ROLL]   <= GAINS_RST;
      cfg_q.gains[AXIS_PITCH]  <= GAINS_RST;
      cfg_q.gains[AXIS_YAW]    <= GAINS_RST;
      cfg_q.target[AXIS_ROLL]  <= ROLL_TARGET_RST;
      cfg_q.target[AXIS_PITCH] <= PITCH_TARGET_RST;
      cfg_q.target[AXIS_YAW]   <= YAW_TARGET_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ROLL_GAINS:   cfg_q.gains[AXIS_ROLL]   <= pwdata[47:0];
        REG_PITCH_GAINS:  cfg_q.gains[AXIS_PITCH]  <= pwdata[47:0];
        REG_YAW_GAINS:    cfg_q.gains[AXIS_YAW]    <= pwdata[47:0];
        REG_ROLL_TARGET:  cfg_q.target[AXIS_ROLL]  <= pwdata[15:0];
        REG_PITCH_TARGET: cfg_q.target[AXIS_PITCH] <= pwdata[15:0];
        REG_YAW_TARGET:   cfg_q.target[AXIS_YAW]   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ROLL_GAINS:   prdata = {16'd0, cfg_q.gains[AXIS_ROLL]};
      REG_PITCH_GAINS:  prdata = {16'd0, cfg_q.gains[AXIS_PITCH]};
      REG_YAW_GAINS:    prdata = {16'd0, cfg_q.gains[AXIS_YAW]};
      REG_ROLL_TARGET:  prdata = {48'd0, cfg_q.target[AXIS_ROLL]};
      REG_PITCH_TARGET: prdata = {48'd0, cfg_q.target[AXIS_PITCH]};
      REG_YAW_TARGET:   prdata = {48'd0, cfg_q.target[AXIS_YAW]};
      default:          prdata = 64'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/tmx_axis_lane.sv =====
// ----------------------------------------------------------------------------
// tmx_axis_lane
// One PID lane: error, saturating error sum and difference, gain products and
// the summed numerator of the axis output.
// ----------------------------------------------------------------------------
module tmx_axis_lane (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tmx_pkg::tmx_adv_t                   adv_i,
  input  logic                                run_i,
  input  logic [47:0]                         gains_i,
  input  logic signed [tmx_pkg::ANGLE_W-1:0]  target_i,
  input  logic signed [tmx_pkg::ANGLE_W-1:0]  measured_i,
  output logic signed [tmx_pkg::NUM_W-1:0]    num_o
);
  import tmx_pkg::*;

  logic signed [SUM_W-1:0]   sum_q;
  logic signed [ERR_W-1:0]   prev_q;

  logic signed [ERR_W-1:0]   err;
  logic signed [SUM_W:0]     sum_wide;
  logic signed [SUM_W-1:0]   sum_d;
  logic signed [DIFF_W-1:0]  diff;

  logic signed [ERR_W-1:0]   err_q;
  logic signed [SUM_W-1:0]   acc_q;
  logic signed [DIFF_W-1:0]  diff_q;

  logic signed [GAIN_W-1:0]  kp, ki, kd;
  logic signed [GAIN_W+ERR_W-1:0]  pe_d, pe_q;
  logic signed [GAIN_W+SUM_W-1:0]  pi_d, pi_q;
  logic signed [GAIN_W+DIFF_W-1:0] pd_d, pd_q;

  logic signed [NUM_W-1:0]   pe_x, pi_x, pd_x, num_d, num_q;

  assign err      = ERR_W'(target_i) - ERR_W'(measured_i);
  assign sum_wide = (SUM_W+1)'(sum_q) + (SUM_W+1)'(err);
  assign sum_d    = (sum_wide[SUM_W] != sum_wide[SUM_W-1]) ?
                    (sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} :
                                       {1'b0, {(SUM_W-1){1'b1}}}) :
                    sum_wide[SUM_W-1:0];
  assign diff     = DIFF_W'(err) - DIFF_W'(prev_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      prev_q <= '0;
    end else if (run_i) begin
      sum_q  <= sum_d;
      prev_q <= err;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.ld_err) begin
      err_q  <= err;
      acc_q  <= sum_d;
      diff_q <= diff;
    end
  end

  assign kp   = gains_i[47:32];
  assign ki   = gains_i[31:16];
  assign kd   = gains_i[15:0];
  assign pe_d = kp * err_q;
  assign pi_d = ki * acc_q;
  assign pd_d = kd * diff_q;

  always_ff @(posedge clk_i) begin
    if (adv_i.ld_prod) begin
      pe_q <= pe_d;
      pi_q <= pi_d;
      pd_q <= pd_d;
    end
  end

  // kp*e*100 + ki*s + kd*d*10000, constant factors as shift-add
  assign pe_x  = NUM_W'(pe_q);
  assign pi_x  = NUM_W'(pi_q);
  assign pd_x  = NUM_W'(pd_q);
  assign num_d = (pe_x <<< 6) + (pe_x <<< 5) + (pe_x <<< 2) + pi_x +
                 (pd_x <<< 13) + (pd_x <<< 10) + (pd_x <<< 9) +
                 (pd_x <<< 8) + (pd_x <<< 4);

  always_ff @(posedge clk_i) begin
    if (adv_i.ld_num) begin
      num_q <= num_d;
    end
  end

  assign num_o = num_q;

endmodule

// ===== hdl/tmx_mix_scale.sv =====
// ----------------------------------------------------------------------------
// tmx_mix_scale
// Mix the lane numerators into elevon and rudder drives, then divide by the
// output scale truncating toward zero and saturate to 16 bits.
// ----------------------------------------------------------------------------
module tmx_mix_scale (
  input  logic                                         clk_i,
  input  tmx_pkg::tmx_adv_t                            adv_i,
  input  logic signed [tmx_pkg::NUM_AXES-1:0][tmx_pkg::NUM_W-1:0] num_i,
  output logic [tmx_pkg::NUM_AXES-1:0][tmx_pkg::DRIVE_W-1:0]      drive_o
);
  import tmx_pkg::*;

  logic signed [MIX_W-1:0] mix [NUM_AXES];
  logic [MIX_W-1:0]        mag [NUM_AXES];
  logic [SHR_W-1:0]        shr [NUM_AXES];

  logic                    neg_q  [NUM_AXES];
  logic                    sat_q  [NUM_AXES];
  logic [MAG_W-1:0]        m_q    [NUM_AXES];

  logic                    neg2_q [NUM_AXES];
  logic                    sat2_q [NUM_AXES];
  logic [MAG_W-1:0]        m2_q   [NUM_AXES];
  logic [MIX_W-1:0]        prod   [NUM_AXES];
  logic [DRIVE_W-1:0]      q0_q   [NUM_AXES];

  logic [MAG_W:0]          q0x    [NUM_AXES];
  logic [MAG_W:0]          rem    [NUM_AXES];
  logic [DRIVE_W-1:0]      quo    [NUM_AXES];
  logic [DRIVE_W-1:0]      res    [NUM_AXES];
  logic [NUM_AXES-1:0][DRIVE_W-1:0] drive_q;

  assign mix[AXIS_ROLL]  = MIX_W'($signed(num_i[AXIS_PITCH])) +
                           MIX_W'($signed(num_i[AXIS_ROLL]));
  assign mix[AXIS_PITCH] = MIX_W'($signed(num_i[AXIS_PITCH])) -
                           MIX_W'($signed(num_i[AXIS_ROLL]));
  assign mix[AXIS_YAW]   = MIX_W'($signed(num_i[AXIS_YAW]));

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      mag[i] = mix[i][MIX_W-1] ? MIX_W'(-mix[i]) : MIX_W'(mix[i]);
      shr[i] = mag[i][MIX_W-1:DIV_SHIFT];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.ld_mix) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        neg_q[i] <= mix[i][MIX_W-1];
        sat_q[i] <= (shr[i] >= SAT_LIM);
        m_q[i]   <= shr[i][MAG_W-1:0];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      prod[i] = MIX_W'(m_q[i]) * MIX_W'(RECIP);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.ld_recip) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        neg2_q[i] <= neg_q[i];
        sat2_q[i] <= sat_q[i];
        m2_q[i]   <= m_q[i];
        q0_q[i]   <= prod[i][RECIP_SH +: DRIVE_W];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      q0x[i] = (MAG_W+1)'(q0_q[i]) * (MAG_W+1)'(DIV_ODD);
      rem[i] = (MAG_W+1)'(m2_q[i]) - q0x[i];
      quo[i] = q0_q[i] + DRIVE_W'(rem[i] >= (MAG_W+1)'(DIV_ODD));
      if (sat2_q[i]) begin
        res[i] = neg2_q[i] ? {1'b1, {(DRIVE_W-1){1'b0}}} : {1'b0, {(DRIVE_W-1){1'b1}}};
      end else begin
        res[i] = neg2_q[i] ? DRIVE_W'(-quo[i]) : quo[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.ld_out) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        drive_q[i] <= res[i];
      end
    end
  end

  assign drive_o = drive_q;

endmodule

// ===== hdl/three_axis_pid_elevon_mixer_core.sv =====
// ----------------------------------------------------------------------------
// three_axis_pid_elevon_mixer_core
// Three-axis PID attitude controller with elevon and rudder mixing.
// ----------------------------------------------------------------------------
// Takes one tick transfer per clock while in_ready_o is high and returns one
// result transfer for each, in order, from the output register. Three PID lanes
// (error and sum, gain products, numerator) feed a shared mixing and scaling
// stage (mix and magnitude, reciprocal multiply, remainder correction into the
// output register); the six-stage pipeline stalls as a whole only when full and
// the result is not taken. Error sums and previous errors update on an input
// transfer in flight, the flight flag on every input transfer. Gains and
// targets are read through the APB port at byte address 8*i.
// ----------------------------------------------------------------------------
module three_axis_pid_elevon_mixer_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [5:0]                          paddr,
  input  logic [63:0]                         pwdata,
  output logic [63:0]                         prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                separated_i,
  input  logic signed [tmx_pkg::ANGLE_W-1:0]  roll_measured_i,
  input  logic signed [tmx_pkg::ANGLE_W-1:0]  pitch_measured_i,
  input  logic signed [tmx_pkg::ANGLE_W-1:0]  yaw_measured_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                in_flight_o,
  output logic signed [tmx_pkg::DRIVE_W-1:0]  elevon_l_o,
  output logic signed [tmx_pkg::DRIVE_W-1:0]  elevon_r_o,
  output logic signed [tmx_pkg::DRIVE_W-1:0]  rudder_o
);
  import tmx_pkg::*;

  localparam int unsigned DEPTH = 6;

  tmx_cfg_t                          cfg;
  tmx_adv_t                          adv;
  logic [DEPTH:1]                    v_q, fl_q;
  logic [DEPTH:0]                    up_v;
  logic [DEPTH:0]                    up_fl;
  logic [DEPTH+1:1]                  rdy;
  logic [DEPTH:1]                    ld;
  logic                              flight_q;
  logic                              fly_now;
  logic                              run;
  logic [NUM_AXES-1:0][ANGLE_W-1:0]  meas;
  logic signed [NUM_AXES-1:0][NUM_W-1:0] num;
  logic [NUM_AXES-1:0][DRIVE_W-1:0]  drive;

  assign pready = 1'b1;

  tmx_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  always_comb begin
    up_v[0]        = in_valid_i;
    up_v[DEPTH:1]  = v_q;
    up_fl[0]       = fly_now;
    up_fl[DEPTH:1] = fl_q;
    rdy[DEPTH+1]   = out_ready_i;
    for (int k = DEPTH; k >= 1; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
      ld[k]  = up_v[k-1] && rdy[k];
    end
  end

  assign in_ready_o   = rdy[1];
  assign adv.ld_err   = ld[1];
  assign adv.ld_prod  = ld[2];
  assign adv.ld_num   = ld[3];
  assign adv.ld_mix   = ld[4];
  assign adv.ld_recip = ld[5];
  assign adv.ld_out   = ld[6];

  assign fly_now = flight_q || separated_i;
  assign run     = ld[1] && fly_now;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q      <= '0;
      fl_q     <= '0;
      flight_q <= 1'b0;
    end else begin
      for (int k = 1; k <= DEPTH; k++) begin
        if (rdy[k]) begin
          v_q[k] <= up_v[k-1];
        end
        if (ld[k]) begin
          fl_q[k] <= up_fl[k-1];
        end
      end
      if (ld[1]) begin
        flight_q <= fly_now;
      end
    end
  end

  assign meas[AXIS_ROLL]  = roll_measured_i;
  assign meas[AXIS_PITCH] = pitch_measured_i;
  assign meas[AXIS_YAW]   = yaw_measured_i;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    tmx_axis_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .adv_i      (adv),
      .run_i      (run),
      .gains_i    (cfg.gains[a]),
      .target_i   (cfg.target[a]),
      .measured_i (meas[a]),
      .num_o      (num[a])
    );
  end

  tmx_mix_scale u_mix (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .num_i   (num),
    .drive_o (drive)
  );

  assign out_valid_o = v_q[DEPTH];
  assign in_flight_o = fl_q[DEPTH];
  assign elevon_l_o  = fl_q[DEPTH] ? drive[AXIS_ROLL]  : '0;
  assign elevon_r_o  = fl_q[DEPTH] ? drive[AXIS_PITCH] : '0;
  assign rudder_o    = fl_q[DEPTH] ? drive[AXIS_YAW]   : '0;

  a_flight_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flight_q |=> flight_q)
    else $error("flight mode dropped");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v_q[DEPTH] && !out_ready_i))
    else $error("input stalled without a blocked output");

  a_flying_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && in_flight_o) |-> flight_q)
    else $error("flying result while waiting");

  a_entry_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v_q[1])
    else $error("transfer not captured in first stage");

endmodule

// ===== tb/elevon_drive_checker.sv =====
// ----------------------------------------------------------------------------
// elevon_drive_checker
// Tracks the gain and target registers from APB writes, predicts the elevon
// and rudder drives of every accepted tick and compares each drive transfer
// against the oldest prediction.
// ----------------------------------------------------------------------------
module elevon_drive_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [5:0]                          paddr,
  input  logic [63:0]                         pwdata,
  input  logic                                pready,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic                                separated_i,
  input  logic signed [tmx_pkg::ANGLE_W-1:0]  roll_measured_i,
  input  logic signed [tmx_pkg::ANGLE_W-1:0]  pitch_measured_i,
  input  logic signed [tmx_pkg::ANGLE_W-1:0]  yaw_measured_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic                                in_flight_i,
  input  logic signed [tmx_pkg::DRIVE_W-1:0]  elevon_l_i,
  input  logic signed [tmx_pkg::DRIVE_W-1:0]  elevon_r_i,
  input  logic signed [tmx_pkg::DRIVE_W-1:0]  rudder_i,
  output int unsigned                         mismatches_o,
  output int unsigned                         pending_o,
  output int unsigned                         checked_o
);
  import tmx_pkg::*;

  localparam int unsigned REG_STRIDE  = 8;
  localparam int unsigned MAX_REPORTS = 10;
  localparam longint      GAIN_ONE    = 4096;
  localparam longint      TICK_RATE   = 100;
  localparam longint      DRIVE_DEN   = GAIN_ONE * TICK_RATE * TICK_RATE;
  localparam longint      SUM_MAX     = 64'sd2147483647;
  localparam longint      SUM_MIN     = -64'sd2147483648;
  localparam longint      DRIVE_MAX   = 32767;
  localparam longint      DRIVE_MIN   = -32768;

  typedef struct packed {
    logic                      in_flight;
    logic signed [DRIVE_W-1:0] left;
    logic signed [DRIVE_W-1:0] right;
    logic signed [DRIVE_W-1:0] rudder;
  } drive_set_t;

  logic [47:0]              gains  [NUM_AXES];
  logic signed [ANGLE_W-1:0] target [NUM_AXES];
  logic                     flying;
  int                       err_sum  [NUM_AXES];
  int                       prev_err [NUM_AXES];
  drive_set_t               expected_drives [$];
  drive_set_t               seen;
  drive_set_t               want;
  int unsigned              reg_idx;

  function automatic logic signed [DRIVE_W-1:0] to_drive(input longint num);
    longint q;
    q = num / DRIVE_DEN;
    if (q > DRIVE_MAX) q = DRIVE_MAX;
    else if (q < DRIVE_MIN) q = DRIVE_MIN;
    return q[DRIVE_W-1:0];
  endfunction

  function automatic drive_set_t predict_tick(input logic sep,
                                              input logic signed [ANGLE_W-1:0] roll,
                                              input logic signed [ANGLE_W-1:0] pitch,
                                              input logic signed [ANGLE_W-1:0] yaw);
    drive_set_t res;
    longint     meas [NUM_AXES];
    longint     num  [NUM_AXES];
    longint     kp, ki, kd, e, d, acc;
    res = '0;
    meas[AXIS_ROLL]  = roll;
    meas[AXIS_PITCH] = pitch;
    meas[AXIS_YAW]   = yaw;
    if (sep) flying = 1'b1;
    if (!flying) return res;
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      kp  = $signed(gains[ax][47:32]);
      ki  = $signed(gains[ax][31:16]);
      kd  = $signed(gains[ax][15:0]);
      e   = longint'(target[ax]) - meas[ax];
      acc = longint'(err_sum[ax]) + e;
      if (acc > SUM_MAX) acc = SUM_MAX;
      else if (acc < SUM_MIN) acc = SUM_MIN;
      err_sum[ax]  = int'(acc);
      d            = e - longint'(prev_err[ax]);
      prev_err[ax] = int'(e);
      num[ax] = kp * e * TICK_RATE + ki * acc + kd * d * TICK_RATE * TICK_RATE;
    end
    res.in_flight = 1'b1;
    res.left      = to_drive(num[AXIS_PITCH] + num[AXIS_ROLL]);
    res.right     = to_drive(num[AXIS_PITCH] - num[AXIS_ROLL]);
    res.rudder    = to_drive(num[AXIS_YAW]);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int ax = 0; ax < NUM_AXES; ax++) begin
        gains[ax]    = GAINS_RST;
        err_sum[ax]  = 0;
        prev_err[ax] = 0;
      end
      target[AXIS_ROLL]  = ROLL_TARGET_RST;
      target[AXIS_PITCH] = PITCH_TARGET_RST;
      target[AXIS_YAW]   = YAW_TARGET_RST;
      flying             = 1'b0;
      expected_drives.delete();
      mismatches_o       = 0;
      pending_o          = 0;
      checked_o          = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        seen.in_flight = in_flight_i;
        seen.left      = elevon_l_i;
        seen.right     = elevon_r_i;
        seen.rudder    = rudder_i;
        if (expected_drives.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= MAX_REPORTS)
            $display("unexpected drive transfer: flight=%0b left=%0d right=%0d rudder=%0d",
                     seen.in_flight, seen.left, seen.right, seen.rudder);
        end else begin
          want = expected_drives.pop_front();
          checked_o++;
          if (seen.in_flight !== want.in_flight || seen.left !== want.left ||
              seen.right !== want.right || seen.rudder !== want.rudder) begin
            mismatches_o++;
            if (mismatches_o <= MAX_REPORTS)
              $display("drive mismatch on result %0d: expected flight=%0b left=%0d right=%0d rudder=%0d, got flight=%0b left=%0d right=%0d rudder=%0d",
                       checked_o, want.in_flight, want.left, want.right, want.rudder,
                       seen.in_flight, seen.left, seen.right, seen.rudder);
          end
        end
      end
      if (in_valid_i && in_ready_i)
        expected_drives.push_back(predict_tick(separated_i, roll_measured_i,
                                               pitch_measured_i, yaw_measured_i));
      if (psel && penable && pwrite && pready) begin
        reg_idx = paddr / REG_STRIDE;
        if (reg_idx < NUM_AXES) gains[reg_idx] = pwdata[47:0];
        else if (reg_idx < 2 * NUM_AXES) target[reg_idx - NUM_AXES] = pwdata[15:0];
      end
      pending_o = expected_drives.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for the three-axis PID elevon mixer core: drives control ticks in
// bursts and gain/target settings over APB, stalls the drive output, and
// leaves prediction and comparison to the drive checker.
// ----------------------------------------------------------------------------
module tb;
  import tmx_pkg::*;

  localparam int unsigned REG_STRIDE    = 8;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned PHASE_TICKS   = 90;
  localparam int unsigned SOAK_TICKS    = 60;
  localparam int unsigned RELEASE_TICKS = 30;
  localparam int unsigned IDLE_CYCLES   = 12;
  localparam int unsigned LIMIT_CYCLES  = 4000000;

  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX  = 16'sh7FFF;
  localparam logic signed [ANGLE_W-1:0] ANGLE_MIN  = 16'sh8000;
  localparam logic signed [ANGLE_W-1:0] FLIGHT_LIM = 16'sd18000;
  localparam logic [GAIN_W-1:0]         GAIN_MAX   = 16'h7FFF;
  localparam logic [GAIN_W-1:0]         GAIN_MIN   = 16'h8000;

  logic                      clk;
  logic                      rst_n;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [5:0]                paddr;
  logic [63:0]               pwdata;
  logic [63:0]               prdata;
  logic                      pready;
  logic                      in_valid;
  logic                      in_ready;
  logic                      separated;
  logic signed [ANGLE_W-1:0] roll_meas;
  logic signed [ANGLE_W-1:0] pitch_meas;
  logic signed [ANGLE_W-1:0] yaw_meas;
  logic                      out_valid;
  logic                      out_ready;
  logic                      in_flight;
  logic signed [DRIVE_W-1:0] elevon_l;
  logic signed [DRIVE_W-1:0] elevon_r;
  logic signed [DRIVE_W-1:0] rudder;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;
  int unsigned burst_left;
  int unsigned ticks_sent;
  int unsigned reg_writes;
  int unsigned settings;
  int unsigned cycles;
  logic [15:0] stall_mask;

  three_axis_pid_elevon_mixer_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .separated_i     (separated),
    .roll_measured_i (roll_meas),
    .pitch_measured_i(pitch_meas),
    .yaw_measured_i  (yaw_meas),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .in_flight_o     (in_flight),
    .elevon_l_o      (elevon_l),
    .elevon_r_o      (elevon_r),
    .rudder_o        (rudder)
  );

  elevon_drive_checker checker_i (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .separated_i     (separated),
    .roll_measured_i (roll_meas),
    .pitch_measured_i(pitch_meas),
    .yaw_measured_i  (yaw_meas),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .in_flight_i     (in_flight),
    .elevon_l_i      (elevon_l),
    .elevon_r_i      (elevon_r),
    .rudder_i        (rudder),
    .mismatches_o    (mismatches),
    .pending_o       (pending),
    .checked_o       (checked)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d drive results outstanding", cycles, pending);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Drive output stalls: rotate a random ready mask, then redraw it and rotate again.
  initial begin
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      if ($urandom_range(0, 3) == 0) stall_mask = 16'hFFFF;
      else stall_mask = 16'($urandom) | 16'($urandom) | 16'h0001;
      repeat (64) begin
        @(negedge clk);
        out_ready  = stall_mask[0];
        stall_mask = {stall_mask[0], stall_mask[15:1]};
      end
    end
  end

  task automatic apb_write(input int unsigned reg_idx, input logic [63:0] data);
    paddr   = 6'(reg_idx * REG_STRIDE);
    pwdata  = data;
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    reg_writes++;
  endtask

  task automatic set_axis(input int unsigned ax, input logic [GAIN_W-1:0] kp,
                          input logic [GAIN_W-1:0] ki, input logic [GAIN_W-1:0] kd,
                          input logic signed [ANGLE_W-1:0] tgt);
    apb_write(ax, {16'd0, kp, ki, kd});
    apb_write(NUM_AXES + ax, {48'd0, tgt});
  endtask

  // Hold the tick until accepted; open a random gap, at times none, before each new burst.
  task automatic send_tick(input logic sep, input logic signed [ANGLE_W-1:0] roll,
                           input logic signed [ANGLE_W-1:0] pitch,
                           input logic signed [ANGLE_W-1:0] yaw);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                              : $urandom_range(1, 16);
    end
    in_valid   = 1'b1;
    separated  = sep;
    roll_meas  = roll;
    pitch_meas = pitch;
    yaw_meas   = yaw;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    burst_left--;
    ticks_sent++;
  endtask

  task automatic drain();
    in_valid   = 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pending != 0);
    repeat (IDLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic signed [ANGLE_W-1:0] rand_angle();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? ANGLE_MAX : ANGLE_MIN;
      1:       return 16'($urandom);
      default: return 16'(int'($urandom_range(0, 36000)) - 18000);
    endcase
  endfunction

  function automatic logic signed [ANGLE_W-1:0] near_angle(
      input logic signed [ANGLE_W-1:0] tgt);
    return 16'(int'(tgt) + int'($urandom_range(0, 2000)) - 1000);
  endfunction

  function automatic logic [GAIN_W-1:0] rand_gain();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 3))
          0:       return GAIN_MAX;
          1:       return GAIN_MIN;
          2:       return '0;
          default: return '1;
        endcase
      end
      1:       return 16'($urandom);
      default: return 16'(int'($urandom_range(0, 16384)) - 8192);
    endcase
  endfunction

  initial begin
    logic signed [ANGLE_W-1:0] tgt [NUM_AXES];
    rst_n      = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid   = 1'b0;
    separated  = 1'b0;
    roll_meas  = '0;
    pitch_meas = '0;
    yaw_meas   = '0;
    burst_left = 0;
    ticks_sent = 0;
    reg_writes = 0;
    settings   = 1;
    cycles     = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // waiting, separation tick, separation ignored in flight, angle extremes
    send_tick(1'b0, '0, '0, '0);
    send_tick(1'b0, ANGLE_MAX, ANGLE_MIN, ANGLE_MAX);
    send_tick(1'b0, ANGLE_MIN, ANGLE_MAX, ANGLE_MIN);
    send_tick(1'b1, 16'sd100, -16'sd400, 16'sd250);
    send_tick(1'b0, '0, '0, '0);
    send_tick(1'b0, 16'sd100, -16'sd400, 16'sd250);
    send_tick(1'b1, FLIGHT_LIM, -FLIGHT_LIM, FLIGHT_LIM);
    send_tick(1'b1, -FLIGHT_LIM, FLIGHT_LIM, -FLIGHT_LIM);
    send_tick(1'b1, 16'sh5555, 16'shAAAA, 16'sh5555);
    send_tick(1'b0, 16'shAAAA, 16'sh5555, 16'shAAAA);
    send_tick(1'b1, ANGLE_MAX, ANGLE_MAX, ANGLE_MAX);
    send_tick(1'b1, ANGLE_MIN, ANGLE_MIN, ANGLE_MIN);

    drain();
    for (int ax = 0; ax < NUM_AXES; ax++)
      set_axis(ax, GAIN_MAX, GAIN_MAX, GAIN_MAX, ANGLE_MAX);
    settings++;
    send_tick(1'b1, ANGLE_MIN, ANGLE_MIN, ANGLE_MIN);
    send_tick(1'b0, ANGLE_MIN, ANGLE_MIN, ANGLE_MIN);
    send_tick(1'b1, ANGLE_MAX, ANGLE_MAX, ANGLE_MAX);

    drain();
    for (int ax = 0; ax < NUM_AXES; ax++)
      set_axis(ax, GAIN_MIN, GAIN_MIN, GAIN_MIN, ANGLE_MIN);
    apb_write(2 * NUM_AXES, '1);
    settings++;
    send_tick(1'b1, ANGLE_MAX, ANGLE_MAX, ANGLE_MAX);
    send_tick(1'b0, ANGLE_MAX, ANGLE_MAX, ANGLE_MAX);
    send_tick(1'b1, ANGLE_MIN, ANGLE_MIN, ANGLE_MIN);

    drain();
    set_axis(AXIS_ROLL, GAIN_MIN, '0, '0, '0);
    set_axis(AXIS_PITCH, GAIN_MAX, '0, '0, '0);
    set_axis(AXIS_YAW, '0, '0, '0, ANGLE_MAX);
    settings++;
    send_tick(1'b1, ANGLE_MAX, ANGLE_MIN, '0);
    send_tick(1'b0, ANGLE_MIN, ANGLE_MAX, ANGLE_MIN);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      for (int ax = 0; ax < NUM_AXES; ax++) begin
        tgt[ax] = rand_angle();
        set_axis(ax, rand_gain(), rand_gain(), rand_gain(), tgt[ax]);
      end
      settings++;
      repeat (PHASE_TICKS) begin
        if ($urandom_range(0, 4) == 0)
          send_tick(1'($urandom_range(0, 1)), rand_angle(), rand_angle(), rand_angle());
        else
          send_tick(1'($urandom_range(0, 1)), near_angle(tgt[AXIS_ROLL]),
                    near_angle(tgt[AXIS_PITCH]), near_angle(tgt[AXIS_YAW]));
      end
    end

    // Push roll and yaw sums upward and pitch downward at the largest error.
    drain();
    for (int ax = 0; ax < NUM_AXES; ax++)
      set_axis(ax, GAINS_RST[47:32], GAINS_RST[31:16], GAINS_RST[15:0],
               (ax == AXIS_PITCH) ? ANGLE_MIN : ANGLE_MAX);
    settings++;
    repeat (SOAK_TICKS)
      send_tick(1'($urandom_range(0, 1)), ANGLE_MIN, ANGLE_MAX, ANGLE_MIN);

    drain();
    for (int ax = 0; ax < NUM_AXES; ax++)
      set_axis(ax, GAINS_RST[47:32], GAINS_RST[31:16], GAINS_RST[15:0],
               (ax == AXIS_PITCH) ? ANGLE_MAX : ANGLE_MIN);
    settings++;
    repeat (RELEASE_TICKS)
      send_tick(1'($urandom_range(0, 1)), ANGLE_MAX, ANGLE_MIN, ANGLE_MAX);

    drain();
    $display("%0d control ticks sent (%0d at the largest error), %0d drive sets checked",
             ticks_sent, SOAK_TICKS + RELEASE_TICKS, checked);
    $display("waiting and flight modes, %0d APB writes over %0d gain/target settings, %0d mismatches",
             reg_writes, settings, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
